/* hdl/lqst_pkg.sv */
package lqst_pkg;

    // default sizes of the slot pool and the template groups
    localparam int SLOTS_DEF     = 64;
    localparam int TEMPLATES_DEF = 16;

    // fixed field widths of the command and result transactions
    localparam int CMD_W  = 2;
    localparam int SLOT_W = 6;
    localparam int TMPL_W = 4;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BUSY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    // read and write strobes of the link tables
    typedef struct packed {
        logic rd_en;
        logic up_we;
        logic tmpl_we;
        logic dn_we;
    } t_link_ctl;

    // update strobes of the per-template counters
    typedef struct packed {
        logic inc;
        logic dec;
    } t_cnt_ctl;

endpackage

/* hdl/lqst_link_store.sv */
module lqst_link_store
    import lqst_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TEMPLATES = TEMPLATES_DEF,
    localparam int IW = $clog2(SLOTS),
    localparam int LW = $clog2(SLOTS + 1),
    localparam int TW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1
) (
    input  logic          i_clk,
    input  t_link_ctl     i_ctl,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_a_addr,
    input  logic [LW-1:0] i_up_data,
    input  logic [TW-1:0] i_tmpl_data,
    input  logic [IW-1:0] i_dn_addr,
    input  logic [LW-1:0] i_dn_data,
    output logic [LW-1:0] o_up,
    output logic [TW-1:0] o_tmpl,
    output logic [LW-1:0] o_dn
);

    // table A holds {template, up link}, table B holds the down link
    logic [TW+LW-1:0] r_mem_a [SLOTS];
    logic [LW-1:0]    r_mem_dn [SLOTS];
    logic [TW+LW-1:0] r_a_q;
    logic [LW-1:0]    r_dn_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.up_we) begin
            r_mem_a[i_a_addr][LW-1:0] <= i_up_data;
        end
        if (i_ctl.tmpl_we) begin
            r_mem_a[i_a_addr][TW+LW-1:LW] <= i_tmpl_data;
        end
        if (i_ctl.dn_we) begin
            r_mem_dn[i_dn_addr] <= i_dn_data;
        end
        if (i_ctl.rd_en) begin
            r_a_q  <= r_mem_a[i_rd_addr];
            r_dn_q <= r_mem_dn[i_rd_addr];
        end
    end

    assign o_up   = r_a_q[LW-1:0];
    assign o_tmpl = r_a_q[TW+LW-1:LW];
    assign o_dn   = r_dn_q;

endmodule

/* hdl/lqst_group_cnt.sv */
module lqst_group_cnt
    import lqst_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TEMPLATES = TEMPLATES_DEF,
    localparam int TW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cnt_ctl      i_ctl,
    input  logic [TW-1:0] i_idx,
    output logic [CW-1:0] o_cnt,
    output logic [CW-1:0] o_cnt_nxt
);

    logic [CW-1:0] r_cnt [TEMPLATES];

    always_comb begin
        o_cnt     = r_cnt[i_idx];
        o_cnt_nxt = o_cnt;
        // saturate at the pool size and at zero
        if (i_ctl.inc && (o_cnt != CW'(SLOTS))) begin
            o_cnt_nxt = o_cnt + CW'(1);
        end else if (i_ctl.dec && (o_cnt != '0)) begin
            o_cnt_nxt = o_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TEMPLATES; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_ctl.inc || i_ctl.dec) begin
            r_cnt[i_idx] <= o_cnt_nxt;
        end
    end

endmodule

/* hdl/lru_query_slot_tracker.sv */
// Channel   Direction  Handshake          Payload
// command   in         i_valid / o_ready  i_command, i_slot, i_template
// result    out        o_valid / i_ready  o_status, o_result_slot, o_result_template,
//                                          o_template_count
//
// One command is worked at a time. Busy insert, touch of the top slot and evict pass
// through S_READ; insert through S_INS1 and, if the list was not empty, S_INS2; a touch
// that moves a slot through S_READ, S_TCH2 and S_TCH3, as each link table has a single
// write port. Answers needing no table access are given on acceptance. A result that
// meets an untaken output result waits in S_OUT until it drains. Reset empties the list,
// clears the valid marks and template counters at once; the link tables need no clearing.
module lru_query_slot_tracker
    import lqst_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TEMPLATES = TEMPLATES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [TMPL_W-1:0] i_template,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [SLOT_W-1:0] o_result_slot,
    output logic [TMPL_W-1:0] o_result_template,
    output logic [CNT_W-1:0]  o_template_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int TW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TCH2 = 3'd2;
    localparam logic [2:0] S_TCH3 = 3'd3;
    localparam logic [2:0] S_INS1 = 3'd4;
    localparam logic [2:0] S_INS2 = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [IW-1:0]     r_slot, n_slot;
    logic [TW-1:0]     r_tp, n_tp;
    logic [LW-1:0]     r_u, n_u;
    logic [LW-1:0]     r_top, n_top;
    logic [LW-1:0]     r_bot, n_bot;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic [TMPL_W-1:0] r_res_tmpl, n_res_tmpl;
    logic [CNT_W-1:0]  r_res_cnt, n_res_cnt;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic [TMPL_W-1:0] r_out_tmpl, n_out_tmpl;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic              w_accept;
    logic              w_out_free;
    logic [31:0]       w_slot_ext;
    logic              w_in_range;
    logic [IW-1:0]     w_slot_idx;
    logic [TW-1:0]     w_tmod [1 << TMPL_W];

    t_link_ctl         w_link_ctl;
    logic [IW-1:0]     w_rd_addr;
    logic [IW-1:0]     w_a_addr;
    logic [LW-1:0]     w_up_data;
    logic [TW-1:0]     w_tmpl_data;
    logic [IW-1:0]     w_dn_addr;
    logic [LW-1:0]     w_dn_data;
    logic [LW-1:0]     w_q_up;
    logic [TW-1:0]     w_q_tmpl;
    logic [LW-1:0]     w_q_dn;

    t_cnt_ctl          w_cnt_ctl;
    logic [TW-1:0]     w_cnt_idx;
    logic [CW-1:0]     w_cnt;
    logic [CW-1:0]     w_cnt_nxt;

    logic              w_fin;
    logic [STAT_W-1:0] w_fin_status;
    logic [SLOT_W-1:0] w_fin_slot;
    logic [TMPL_W-1:0] w_fin_tmpl;
    logic [CNT_W-1:0]  w_fin_cnt;

    // template reduction table, worked out at elaboration
    genvar k;
    for (k = 0; k < (1 << TMPL_W); k++) begin : g_tmod
        assign w_tmod[k] = TW'(k % TEMPLATES);
    end

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_slot_ext = 32'(i_slot);
    assign w_in_range = (w_slot_ext < 32'(SLOTS));
    assign w_slot_idx = w_slot_ext[IW-1:0];

    lqst_link_store #(
        .SLOTS     (SLOTS),
        .TEMPLATES (TEMPLATES)
    ) u_links (
        .i_clk       (i_clk),
        .i_ctl       (w_link_ctl),
        .i_rd_addr   (w_rd_addr),
        .i_a_addr    (w_a_addr),
        .i_up_data   (w_up_data),
        .i_tmpl_data (w_tmpl_data),
        .i_dn_addr   (w_dn_addr),
        .i_dn_data   (w_dn_data),
        .o_up        (w_q_up),
        .o_tmpl      (w_q_tmpl),
        .o_dn        (w_q_dn)
    );

    lqst_group_cnt #(
        .SLOTS     (SLOTS),
        .TEMPLATES (TEMPLATES)
    ) u_counts (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_cnt_ctl),
        .i_idx     (w_cnt_idx),
        .o_cnt     (w_cnt),
        .o_cnt_nxt (w_cnt_nxt)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_tp         = r_tp;
        n_u          = r_u;
        n_top        = r_top;
        n_bot        = r_bot;
        n_valid      = r_valid;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_tmpl   = r_res_tmpl;
        n_res_cnt    = r_res_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_tmpl   = r_out_tmpl;
        n_out_cnt    = r_out_cnt;

        w_link_ctl   = '0;
        w_rd_addr    = (i_command == CMD_EVICT) ? r_bot[IW-1:0] : w_slot_idx;
        w_a_addr     = r_slot;
        w_up_data    = NIL;
        w_tmpl_data  = r_tp;
        w_dn_addr    = r_slot;
        w_dn_data    = NIL;
        w_cnt_ctl    = '0;
        w_cnt_idx    = r_tp;

        w_fin        = 1'b0;
        w_fin_status = ST_OK;
        w_fin_slot   = '0;
        w_fin_tmpl   = '0;
        w_fin_cnt    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_command;
                    n_slot = w_slot_idx;
                    n_tp   = w_tmod[i_template];
                    unique case (i_command)
                        CMD_INSERT: begin
                            if (!w_in_range) begin
                                w_fin        = 1'b1;
                                w_fin_status = ST_ABSENT;
                                w_fin_slot   = i_slot;
                            end else if (r_valid[w_slot_idx]) begin
                                w_link_ctl.rd_en = 1'b1;
                                n_state          = S_READ;
                            end else begin
                                n_state = S_INS1;
                            end
                        end
                        CMD_TOUCH: begin
                            if (!(w_in_range && r_valid[w_slot_idx])) begin
                                w_fin        = 1'b1;
                                w_fin_status = ST_ABSENT;
                                w_fin_slot   = i_slot;
                            end else begin
                                w_link_ctl.rd_en = 1'b1;
                                n_state          = S_READ;
                            end
                        end
                        CMD_EVICT: begin
                            if (r_bot == NIL) begin
                                w_fin        = 1'b1;
                                w_fin_status = ST_EMPTY;
                            end else begin
                                n_slot           = r_bot[IW-1:0];
                                w_link_ctl.rd_en = 1'b1;
                                n_state          = S_READ;
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_cnt_idx = w_q_tmpl;
                n_tp      = w_q_tmpl;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        w_fin        = 1'b1;
                        w_fin_status = ST_BUSY;
                        w_fin_slot   = SLOT_W'(r_slot);
                        w_fin_tmpl   = TMPL_W'(w_q_tmpl);
                        w_fin_cnt    = CNT_W'(w_cnt);
                    end
                    CMD_TOUCH: begin
                        if (r_top == LW'(r_slot)) begin
                            w_fin        = 1'b1;
                            w_fin_slot   = SLOT_W'(r_slot);
                            w_fin_tmpl   = TMPL_W'(w_q_tmpl);
                            w_fin_cnt    = CNT_W'(w_cnt);
                        end else begin
                            // unlink: a slot below the top always has an upper neighbor
                            w_link_ctl.dn_we = 1'b1;
                            w_dn_addr        = w_q_up[IW-1:0];
                            w_dn_data        = w_q_dn;
                            if (w_q_dn == NIL) begin
                                n_bot = w_q_up;
                            end else begin
                                w_link_ctl.up_we = 1'b1;
                                w_a_addr         = w_q_dn[IW-1:0];
                                w_up_data        = w_q_up;
                            end
                            n_state = S_TCH2;
                        end
                    end
                    CMD_EVICT: begin
                        // the bottom slot has no lower neighbor
                        if (w_q_up == NIL) begin
                            n_top = NIL;
                        end else begin
                            w_link_ctl.dn_we = 1'b1;
                            w_dn_addr        = w_q_up[IW-1:0];
                            w_dn_data        = NIL;
                        end
                        n_bot           = w_q_up;
                        n_valid[r_slot] = 1'b0;
                        w_cnt_ctl.dec   = 1'b1;
                        w_fin           = 1'b1;
                        w_fin_slot      = SLOT_W'(r_slot);
                        w_fin_tmpl      = TMPL_W'(w_q_tmpl);
                        w_fin_cnt       = CNT_W'(w_cnt_nxt);
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_TCH2: begin
                // link on top: the list holds at least two slots here
                w_link_ctl.dn_we = 1'b1;
                w_dn_data        = r_top;
                w_link_ctl.up_we = 1'b1;
                w_a_addr         = r_top[IW-1:0];
                w_up_data        = LW'(r_slot);
                n_top            = LW'(r_slot);
                n_state          = S_TCH3;
            end
            S_TCH3: begin
                w_link_ctl.up_we = 1'b1;
                w_fin            = 1'b1;
                w_fin_slot       = SLOT_W'(r_slot);
                w_fin_tmpl       = TMPL_W'(r_tp);
                w_fin_cnt        = CNT_W'(w_cnt);
            end
            S_INS1: begin
                w_link_ctl.up_we   = 1'b1;
                w_link_ctl.tmpl_we = 1'b1;
                w_link_ctl.dn_we   = 1'b1;
                w_dn_data          = r_top;
                n_top              = LW'(r_slot);
                n_u                = r_top;
                n_valid[r_slot]    = 1'b1;
                w_cnt_ctl.inc      = 1'b1;
                if (r_top == NIL) begin
                    n_bot      = LW'(r_slot);
                    w_fin      = 1'b1;
                    w_fin_slot = SLOT_W'(r_slot);
                    w_fin_tmpl = TMPL_W'(r_tp);
                    w_fin_cnt  = CNT_W'(w_cnt_nxt);
                end else begin
                    n_state = S_INS2;
                end
            end
            S_INS2: begin
                // point the old top up at the new slot
                w_link_ctl.up_we = 1'b1;
                w_a_addr         = r_u[IW-1:0];
                w_up_data        = LW'(r_slot);
                w_fin            = 1'b1;
                w_fin_slot       = SLOT_W'(r_slot);
                w_fin_tmpl       = TMPL_W'(r_tp);
                w_fin_cnt        = CNT_W'(w_cnt);
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_tmpl   = r_res_tmpl;
                    n_out_cnt    = r_res_cnt;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register, or hold it until that drains
        if (w_fin) begin
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = w_fin_status;
                n_out_slot   = w_fin_slot;
                n_out_tmpl   = w_fin_tmpl;
                n_out_cnt    = w_fin_cnt;
                n_state      = S_IDLE;
            end else begin
                n_res_status = w_fin_status;
                n_res_slot   = w_fin_slot;
                n_res_tmpl   = w_fin_tmpl;
                n_res_cnt    = w_fin_cnt;
                n_state      = S_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= NIL;
            r_bot       <= NIL;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_slot       <= n_slot;
        r_tp         <= n_tp;
        r_u          <= n_u;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_tmpl   <= n_res_tmpl;
        r_res_cnt    <= n_res_cnt;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_tmpl   <= n_out_tmpl;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_result_slot     = r_out_slot;
    assign o_result_template = r_out_tmpl;
    assign o_template_count  = r_out_cnt;

endmodule
